[rtl/adc_level_hysteresis_debounce_unit_defines.svh]
// Assertion macros for the level hysteresis/debounce unit.
`ifndef ADC_LEVEL_HYSTERESIS_DEBOUNCE_UNIT_DEFINES_SVH
`define ADC_LEVEL_HYSTERESIS_DEBOUNCE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define ADCHD_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("adchd assertion failed");
`define ADCHD_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("adchd assertion failed");
`else
`define ADCHD_ASSERT(name, clk, rst_n, prop)
`define ADCHD_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

[rtl/adchd_pkg.sv]
package adchd_pkg;

  localparam int unsigned CHANNELS   = 14;
  localparam int unsigned LEVELS     = 33;
  localparam int unsigned SAMPLE_MAX = 4095;

  localparam int unsigned CHAN_W   = 4;
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned LEVEL_W  = 6;
  localparam int unsigned STABLE_W = 8;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned BAND_W   = 12;
  localparam int unsigned THR_W    = 4;

  localparam int unsigned STEP        = (SAMPLE_MAX + 1) / LEVELS;
  // ceil(2^SHIFT / STEP); exact floor division for every SAMPLE_W-bit sample
  localparam int unsigned RECIP_SHIFT = 2 * SAMPLE_W;
  localparam longint unsigned RECIP   = ((64'd1 << RECIP_SHIFT) + STEP - 1) / STEP;
  localparam int unsigned RECIP_W     = $clog2(RECIP + 1);
  localparam int unsigned CENTER_W    = STABLE_W + SAMPLE_W;

  localparam logic [STABLE_W-1:0] NO_LEVEL  = 8'hFF;
  localparam logic [COUNT_W-1:0]  COUNT_MAX = 5'd31;

  localparam logic [CHAN_W-1:0] RST_CHANNEL_COUNT     = 4'd0;
  localparam logic [BAND_W-1:0] RST_HYSTERESIS_BAND   = 12'd30;
  localparam logic [THR_W-1:0]  RST_CONFIRM_THRESHOLD = 4'd3;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_CHANNEL_COUNT     = 2'd0,
    REG_HYSTERESIS_BAND   = 2'd1,
    REG_CONFIRM_THRESHOLD = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [CHAN_W-1:0] channel_count;
    logic [BAND_W-1:0] hysteresis_band;
    logic [THR_W-1:0]  confirm_threshold;
  } cfg_t;

  typedef struct packed {
    logic               emit;
    logic [LEVEL_W-1:0] level;
  } decision_t;

endpackage

[rtl/adchd_regs.sv]
module adchd_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [adchd_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [adchd_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [adchd_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                pready,
  output adchd_pkg::cfg_t                     cfg_o
);

  adchd_pkg::cfg_t      cfg_q, cfg_d;
  adchd_pkg::reg_idx_e  idx;
  logic                 wr_en;

  assign idx    = adchd_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        adchd_pkg::REG_CHANNEL_COUNT:
          cfg_d.channel_count = pwdata[adchd_pkg::CHAN_W-1:0];
        adchd_pkg::REG_HYSTERESIS_BAND:
          cfg_d.hysteresis_band = pwdata[adchd_pkg::BAND_W-1:0];
        adchd_pkg::REG_CONFIRM_THRESHOLD:
          cfg_d.confirm_threshold = pwdata[adchd_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      adchd_pkg::REG_CHANNEL_COUNT:
        prdata = adchd_pkg::APB_DATA_W'(cfg_q.channel_count);
      adchd_pkg::REG_HYSTERESIS_BAND:
        prdata = adchd_pkg::APB_DATA_W'(cfg_q.hysteresis_band);
      adchd_pkg::REG_CONFIRM_THRESHOLD:
        prdata = adchd_pkg::APB_DATA_W'(cfg_q.confirm_threshold);
      default:
        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel_count     <= adchd_pkg::RST_CHANNEL_COUNT;
      cfg_q.hysteresis_band   <= adchd_pkg::RST_HYSTERESIS_BAND;
      cfg_q.confirm_threshold <= adchd_pkg::RST_CONFIRM_THRESHOLD;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

[rtl/adchd_quant.sv]
module adchd_quant (
  input  logic [adchd_pkg::SAMPLE_W-1:0] sample_i,
  output logic [adchd_pkg::LEVEL_W-1:0]  level_o
);

  localparam int unsigned PROD_W = adchd_pkg::SAMPLE_W + adchd_pkg::RECIP_W;
  localparam int unsigned QUOT_W = PROD_W - adchd_pkg::RECIP_SHIFT;

  logic [PROD_W-1:0] prod;
  logic [QUOT_W-1:0] quot;

  // divide by STEP through the reciprocal
  assign prod    = PROD_W'(sample_i) * PROD_W'(adchd_pkg::RECIP);
  assign quot    = prod[adchd_pkg::RECIP_SHIFT +: QUOT_W];
  assign level_o = (quot > QUOT_W'(adchd_pkg::LEVELS - 1))
                 ? adchd_pkg::LEVEL_W'(adchd_pkg::LEVELS - 1)
                 : adchd_pkg::LEVEL_W'(quot);

endmodule

[rtl/adchd_core.sv]
module adchd_core #(
  parameter int unsigned CHANNELS = adchd_pkg::CHANNELS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  adchd_pkg::cfg_t                cfg_i,
  input  logic [adchd_pkg::CHAN_W-1:0]   channel_i,
  input  logic [adchd_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                           update_i,
  output adchd_pkg::decision_t           dec_o
);

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CMP_W = adchd_pkg::CHAN_W + 1;
  localparam int unsigned CW    = adchd_pkg::CENTER_W;

  logic [adchd_pkg::STABLE_W-1:0] stable_q [CHANNELS];
  logic [adchd_pkg::COUNT_W-1:0]  count_q  [CHANNELS];

  logic [adchd_pkg::LEVEL_W-1:0]  level;
  logic [IDX_W-1:0]               idx;
  logic                           in_range;
  logic [adchd_pkg::STABLE_W-1:0] prev;
  logic [adchd_pkg::COUNT_W-1:0]  cnt, cnt_inc;
  logic [CW-1:0]                  center, smp_ext, delta;
  logic                           near, differ, accept;

  adchd_quant u_quant (
    .sample_i (sample_i),
    .level_o  (level)
  );

  assign in_range = (CMP_W'(channel_i) < CMP_W'(cfg_i.channel_count))
                 && (CMP_W'(channel_i) < CMP_W'(CHANNELS));
  assign idx      = channel_i[IDX_W-1:0];
  assign prev     = stable_q[idx];
  assign cnt      = count_q[idx];

  assign center  = CW'(prev) * CW'(adchd_pkg::STEP) + CW'(adchd_pkg::STEP / 2);
  assign smp_ext = CW'(sample_i);
  assign delta   = (smp_ext >= center) ? (smp_ext - center) : (center - smp_ext);
  assign near    = delta < CW'(cfg_i.hysteresis_band);
  assign differ  = adchd_pkg::STABLE_W'(level) != prev;
  assign cnt_inc = (cnt == adchd_pkg::COUNT_MAX) ? cnt : cnt + 1'b1;
  assign accept  = cnt_inc > adchd_pkg::COUNT_W'(cfg_i.confirm_threshold);

  assign dec_o.emit  = in_range & ~near & differ & accept;
  assign dec_o.level = level;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        stable_q[i] <= adchd_pkg::NO_LEVEL;
        count_q[i]  <= '0;
      end
    end else if (update_i && in_range) begin
      if (near || !differ) begin
        count_q[idx] <= '0;
      end else if (accept) begin
        stable_q[idx] <= adchd_pkg::STABLE_W'(level);
        count_q[idx]  <= '0;
      end else begin
        count_q[idx] <= cnt_inc;
      end
    end
  end

endmodule

[rtl/adc_level_hysteresis_debounce_unit.sv]
// Quantizes 12-bit slider samples to levels 0..32 (step 124) and reports a
// channel's level only after it has differed from the stored level more than
// confirm_threshold times in a row and lies outside the hysteresis band of the
// stored level's center. Takes one sample per clock while the output is not
// stalled: the per-channel state sits in flip-flops and is read, decided and
// written between the input register and the result register, with no
// bubbles between samples. No clearing pass after reset. Registers at APB byte
// addresses 0x0 channel_count, 0x4 hysteresis_band, 0x8 confirm_threshold;
// write them only while idle.
`include "adc_level_hysteresis_debounce_unit_defines.svh"

module adc_level_hysteresis_debounce_unit #(
  parameter int unsigned CHANNELS = adchd_pkg::CHANNELS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [adchd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [adchd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [adchd_pkg::APB_DATA_W-1:0] prdata,
  output logic                             pready,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [15:0]                      s_axis_tdata,  // channel[3:0], sample[15:4]
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [15:0]                      m_axis_tdata   // event_channel[3:0], new_level[9:4]
);

  adchd_pkg::cfg_t      cfg;
  adchd_pkg::decision_t dec;

  logic                           s1_valid_q, s1_valid_d;
  logic [adchd_pkg::CHAN_W-1:0]   s1_chan_q;
  logic [adchd_pkg::SAMPLE_W-1:0] s1_smp_q;
  logic                           out_valid_q, out_valid_d;
  logic [adchd_pkg::CHAN_W-1:0]   out_chan_q;
  logic [adchd_pkg::LEVEL_W-1:0]  out_level_q;
  logic                           advance, in_fire, out_load;

  adchd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  adchd_core #(
    .CHANNELS (CHANNELS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .channel_i (s1_chan_q),
    .sample_i  (s1_smp_q),
    .update_i  (s1_valid_q & advance),
    .dec_o     (dec)
  );

  assign advance       = ~out_valid_q | m_axis_tready;
  assign s_axis_tready = ~s1_valid_q | advance;
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign out_load      = advance & s1_valid_q & dec.emit;
  assign s1_valid_d    = s_axis_tready ? s_axis_tvalid : s1_valid_q;
  assign out_valid_d   = advance ? (s1_valid_q & dec.emit) : out_valid_q;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_level_q, out_chan_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_chan_q <= s_axis_tdata[3:0];
      s1_smp_q  <= s_axis_tdata[15:4];
    end
    if (out_load) begin
      out_chan_q  <= s1_chan_q;
      out_level_q <= dec.level;
    end
  end

  `ADCHD_ASSERT(a_out_from_stage, clk_i, rst_ni, $rose(out_valid_q) |-> $past(s1_valid_q))
  `ADCHD_ASSERT(a_stall_only_full, clk_i, rst_ni, !s_axis_tready |-> s1_valid_q && out_valid_q)
  `ADCHD_ASSERT(a_event_range, clk_i, rst_ni, out_valid_q |-> (out_chan_q < adchd_pkg::CHAN_W'(CHANNELS) || CHANNELS == 16) && out_level_q <= adchd_pkg::LEVEL_W'(adchd_pkg::LEVELS - 1))
  `ADCHD_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !m_axis_tvalid && s_axis_tready)

endmodule

[tb/adc_level_hysteresis_debounce_unit_test.sv]
module adc_level_hysteresis_debounce_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [adchd_pkg::APB_ADDR_W-1:0] UNMAPPED_ADDR = 4'hC;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef struct {
    logic [adchd_pkg::CHAN_W-1:0]  chan;
    logic [adchd_pkg::LEVEL_W-1:0] level;
  } level_event_t;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [adchd_pkg::APB_ADDR_W-1:0] paddr;
  logic [adchd_pkg::APB_DATA_W-1:0] pwdata;
  logic [adchd_pkg::APB_DATA_W-1:0] prdata;
  logic                             pready;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [15:0]                      s_axis_tdata;  // channel[3:0], sample[15:4]
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  logic [15:0]                      m_axis_tdata;  // event_channel[3:0], new_level[9:4], zero[15:10]

  adc_level_hysteresis_debounce_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // predictor state and configuration
  logic [adchd_pkg::STABLE_W-1:0] stable_lvl [adchd_pkg::CHANNELS];
  logic [adchd_pkg::COUNT_W-1:0]  pend_cnt   [adchd_pkg::CHANNELS];
  int unsigned                    cfg_channels;
  int unsigned                    cfg_band;
  int unsigned                    cfg_thresh;

  level_event_t pending_level_events[$];
  int unsigned  mismatch_count;
  int unsigned  active_items;
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;
  int unsigned  quiet_cycles;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  task automatic track_channel_level(input logic [adchd_pkg::CHAN_W-1:0] ch,
                                     input logic [adchd_pkg::SAMPLE_W-1:0] smp);
    int unsigned  lvl;
    int unsigned  prev;
    int unsigned  center;
    int unsigned  delta;
    int unsigned  cnt;
    level_event_t ev;
    if (ch >= cfg_channels || ch >= adchd_pkg::CHANNELS) return;
    active_items++;
    lvl = 32'(smp) / adchd_pkg::STEP;
    if (lvl > adchd_pkg::LEVELS - 1) lvl = adchd_pkg::LEVELS - 1;
    prev   = 32'(stable_lvl[ch]);
    center = prev * adchd_pkg::STEP + adchd_pkg::STEP / 2;
    delta  = (32'(smp) >= center) ? 32'(smp) - center : center - 32'(smp);
    if (delta < cfg_band) begin
      pend_cnt[ch] = '0;
      return;
    end
    if (lvl != prev) begin
      cnt = 32'(pend_cnt[ch]);
      if (cnt < 32'(adchd_pkg::COUNT_MAX)) cnt++;
      if (cnt > cfg_thresh) begin
        stable_lvl[ch] = adchd_pkg::STABLE_W'(lvl);
        pend_cnt[ch]   = '0;
        ev.chan  = ch;
        ev.level = adchd_pkg::LEVEL_W'(lvl);
        pending_level_events.push_back(ev);
      end else begin
        pend_cnt[ch] = adchd_pkg::COUNT_W'(cnt);
      end
    end else begin
      pend_cnt[ch] = '0;
    end
  endtask

  task automatic send_sample(input logic [adchd_pkg::CHAN_W-1:0] ch,
                             input logic [adchd_pkg::SAMPLE_W-1:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {smp, ch};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    track_channel_level(ch, smp);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_level_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [adchd_pkg::APB_ADDR_W-1:0] addr,
                           input logic [adchd_pkg::APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_register(input adchd_pkg::reg_idx_e idx, input int unsigned value);
    apb_write({idx, 2'b00}, value);
    case (idx)
      adchd_pkg::REG_CHANNEL_COUNT:     cfg_channels = value & 32'hF;
      adchd_pkg::REG_HYSTERESIS_BAND:   cfg_band     = value & 32'hFFF;
      adchd_pkg::REG_CONFIRM_THRESHOLD: cfg_thresh   = value & 32'hF;
      default: ;
    endcase
  endtask

  task automatic configure(input int unsigned chans, input int unsigned band,
                           input int unsigned thresh);
    drain();
    set_register(adchd_pkg::REG_CHANNEL_COUNT, chans);
    set_register(adchd_pkg::REG_HYSTERESIS_BAND, band);
    set_register(adchd_pkg::REG_CONFIRM_THRESHOLD, thresh);
  endtask

  function automatic logic [adchd_pkg::SAMPLE_W-1:0] sample_in_level(input int unsigned lvl);
    if (lvl >= adchd_pkg::LEVELS - 1)
      return adchd_pkg::SAMPLE_W'((adchd_pkg::LEVELS - 1) * adchd_pkg::STEP +
             $urandom_range(adchd_pkg::SAMPLE_MAX -
                            (adchd_pkg::LEVELS - 1) * adchd_pkg::STEP));
    return adchd_pkg::SAMPLE_W'(lvl * adchd_pkg::STEP + $urandom_range(adchd_pkg::STEP - 1));
  endfunction

  // nothing is reported while no channel is enabled
  task automatic test_disabled();
    set_register(adchd_pkg::REG_CHANNEL_COUNT, 0);
    send_sample(4'd0, 12'd4095);
    send_sample(4'd0, 12'd4095);
    send_sample(4'd0, 12'd4095);
    send_sample(4'd0, 12'd4095);
  endtask

  // first level per channel, clamping, channels past the active range
  task automatic test_first_level();
    configure(adchd_pkg::CHANNELS, 0, 0);
    send_sample(4'd0, 12'd0);
    send_sample(4'd13, 12'd4095);
    send_sample(4'd1, 12'd4092);
    send_sample(4'd14, 12'd1000);
    send_sample(4'd15, 12'd2000);
  endtask

  task automatic test_hysteresis();
    configure(adchd_pkg::CHANNELS, 30, 0);
    send_sample(4'd0, 12'd91);
    send_sample(4'd0, 12'd124);
    configure(adchd_pkg::CHANNELS, 100, 0);
    send_sample(4'd0, 12'd250);
    send_sample(4'd0, 12'd4095);
  endtask

  // pending count survives a threshold drop; unmapped write has no effect
  task automatic test_threshold_drop();
    configure(adchd_pkg::CHANNELS, 0, 15);
    apb_write(UNMAPPED_ADDR, 32'hFFFF_FFFF);
    repeat (10) send_sample(4'd2, 12'd2000);
    drain();
    set_register(adchd_pkg::REG_CONFIRM_THRESHOLD, 2);
    send_sample(4'd2, 12'd2000);
  endtask

  task automatic test_random_traffic(input int unsigned n_items, input int unsigned chans,
                                     input int unsigned band, input int unsigned thresh);
    int unsigned target;
    int unsigned ch;
    int unsigned lvl;
    int unsigned run_len;
    configure(chans, band, thresh);
    target = active_items + n_items;
    while (active_items < target) begin
      if ($urandom_range(99) < 70) begin
        ch      = $urandom_range(chans - 1);
        lvl     = $urandom_range(adchd_pkg::LEVELS - 1);
        run_len = $urandom_range(thresh + 3, 1);
        repeat (run_len) send_sample(adchd_pkg::CHAN_W'(ch), sample_in_level(lvl));
      end else begin
        send_sample(adchd_pkg::CHAN_W'($urandom_range(15)),
                    adchd_pkg::SAMPLE_W'($urandom_range(adchd_pkg::SAMPLE_MAX)));
      end
    end
  endtask

  always @(posedge clk_i) begin
    level_event_t ev;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_level_events.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected level event: channel %0d level %0d",
                   m_axis_tdata[3:0], m_axis_tdata[9:4]);
      end else begin
        ev = pending_level_events.pop_front();
        if (m_axis_tdata[3:0] !== ev.chan || m_axis_tdata[9:4] !== ev.level ||
            m_axis_tdata[15:10] !== '0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("level event mismatch: exp channel %0d level %0d, got tdata %h",
                     ev.chan, ev.level, m_axis_tdata);
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("adc_level_hysteresis_debounce_unit_test NOT OK");
      $finish;
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    s_axis_tvalid  <= 1'b0;
    s_axis_tdata   <= '0;
    active_items   = 0;
    cfg_channels   = 32'(adchd_pkg::RST_CHANNEL_COUNT);
    cfg_band       = 32'(adchd_pkg::RST_HYSTERESIS_BAND);
    cfg_thresh     = 32'(adchd_pkg::RST_CONFIRM_THRESHOLD);
    for (int i = 0; i < adchd_pkg::CHANNELS; i++) begin
      stable_lvl[i] = adchd_pkg::NO_LEVEL;
      pend_cnt[i]   = '0;
    end
    send_idle_pct = 31;
    recv_idle_pct = 88;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_disabled();
    test_first_level();
    test_hysteresis();
    test_threshold_drop();

    test_random_traffic(110, adchd_pkg::CHANNELS, 30, 3);
    test_random_traffic(80, 15, 0, 0);
    send_idle_pct = 88;
    recv_idle_pct = 31;
    test_random_traffic(100, adchd_pkg::CHANNELS, 124, 1);
    test_random_traffic(40, 5, 4095, 15);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(100, adchd_pkg::CHANNELS, 0, 15);
    test_random_traffic(80, adchd_pkg::CHANNELS, 60, 2);

    drain();
    if (pending_level_events.size() != 0)
      $display("%0d expected level events never arrived", pending_level_events.size());
    if (mismatch_count == 0 && pending_level_events.size() == 0) begin
      $display("adc_level_hysteresis_debounce_unit_test OK");
    end else begin
      $display("adc_level_hysteresis_debounce_unit_test NOT OK");
    end
    $finish;
  end

endmodule
